### sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

	localparam int DATA_W    = 32;
	localparam int OCC_W     = 5;
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 40;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} spq_op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} spq_entry_t;

	// Command broadcast to every cell in the chain.
	typedef struct packed {
		logic       enq;
		logic       deq;
		spq_entry_t item;
	} spq_cmd_t;

endpackage

`default_nettype wire

### sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, occupancy count and result register.
`default_nettype none

// Bounded min-priority queue of CAPACITY entries held in a chain of cells sorted by
// ascending priority, head in cell 0. Each cell compares its own priority against an
// incoming item in parallel, so every cell updates together on an enqueue or dequeue and the
// block takes one request per clock while not stalled; the result appears on the
// master side in the cycle after acceptance. A single output register holds the
// result; the slave side stalls only while that register is full and m_tready is
// low. An enqueue into a full queue is dropped with overflow set; a dequeue of an
// empty queue returns -1 with underflow set. Occupancy reports the count after the
// request, low five bits. No clearing pass is needed after reset.
module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [31:0] item_value, [63:32] item_priority
	input  wire logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
	// [0] opcode
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [31:0] dequeued_value, [32] underflow, [33] overflow, [38:34] occupancy, [39] zero
	output logic [spq_pkg::M_TDATA_W-1:0]        m_tdata
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	spq_entry_t        ent   [CAPACITY];
	logic              vld   [CAPACITY];
	logic              tk    [CAPACITY];
	spq_cmd_t          cmd;
	spq_op_t           op;
	logic              accept;
	logic              full;
	logic              empty;
	logic              underflow;
	logic              overflow;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [CNT_W+OCC_W-1:0] count_ext;
	logic signed [DATA_W-1:0] result;
	logic              m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = spq_op_t'(s_tuser);
	assign full     = vld[CAPACITY-1];
	assign empty    = !vld[0];

	always_comb begin
		cmd.item.value = s_tdata[DATA_W-1:0];
		cmd.item.prio  = s_tdata[2*DATA_W-1:DATA_W];
		cmd.enq        = accept && (op == OP_ENQUEUE) && !full;
		cmd.deq        = accept && (op == OP_DEQUEUE) && !empty;
		underflow      = (op == OP_DEQUEUE) && empty;
		overflow       = (op == OP_ENQUEUE) && full;
		result         = cmd.deq ? ent[0].value : EMPTY_VALUE;
		if (cmd.enq) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd.deq) begin
			count_nxt = count_q - CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
		count_ext = (CNT_W+OCC_W)'(count_nxt);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_entry_t le;
		logic       lv;
		logic       lt;
		spq_entry_t re;
		logic       rv;

		if (i == 0) begin : g_head
			assign le = cmd.item;
			assign lv = 1'b1;
			assign lt = 1'b0;
		end else begin : g_body
			assign le = ent[i-1];
			assign lv = vld[i-1];
			assign lt = tk[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign re = ent[i];
			assign rv = 1'b0;
		end else begin : g_inner
			assign re = ent[i+1];
			assign rv = vld[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.head        (i == 0),
			.cmd         (cmd),
			.left_entry  (le),
			.left_valid  (lv),
			.left_take   (lt),
			.right_entry (re),
			.right_valid (rv),
			.entry       (ent[i]),
			.valid       (vld[i]),
			.take        (tk[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {1'b0, count_ext[OCC_W-1:0], overflow, underflow, result};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

### sv/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none

module spq_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head,
	input  wire spq_pkg::spq_cmd_t   cmd,
	input  wire spq_pkg::spq_entry_t left_entry,
	input  wire logic                left_valid,
	input  wire logic                left_take,
	input  wire spq_pkg::spq_entry_t right_entry,
	input  wire logic                right_valid,
	output spq_pkg::spq_entry_t      entry,
	output logic                     valid,
	output logic                     take
);
	import spq_pkg::*;

	spq_entry_t entry_q;
	logic       valid_q;
	logic       cmp;

	// The head yields only to a strictly smaller priority; other cells yield on ties.
	always_comb begin
		if (head) begin
			cmp = entry_q.prio > cmd.item.prio;
		end else begin
			cmp = entry_q.prio >= cmd.item.prio;
		end
		take = !valid_q || cmp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.enq) begin
			valid_q <= left_valid;
		end else if (cmd.deq) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq && take) begin
			// advance the left neighbor's entry, or drop the new item in here
			entry_q <= left_take ? left_entry : cmd.item;
		end else if (cmd.deq) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

`default_nettype wire
